/* src/fkwd_pkg.sv */
// Package for the four-key window debouncer: types, sizes and event codes.
package fkwd_pkg;

	localparam int NUM_KEYS      = 4;
	localparam int WINDOW_LENGTH = 20;
	localparam int POS_W         = $clog2(WINDOW_LENGTH + 1);

	typedef logic [NUM_KEYS-1:0] keys_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [3:0]          event_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	localparam event_t EV_NONE = 4'd0;

	// Pressed and released codes per key: up, down, enter, escape.
	localparam event_t PRESS_CODE   [NUM_KEYS] = '{4'd1, 4'd3, 4'd5, 4'd7};
	localparam event_t RELEASE_CODE [NUM_KEYS] = '{4'd2, 4'd4, 4'd6, 4'd8};

	typedef struct packed {
		cmd_t  command;
		keys_t levels;
	} item_t;

	typedef struct packed {
		logic   valid;
		event_t code;
	} result_t;

endpackage

/* src/four_key_window_debouncer.sv */
// Top level of the four-key window debouncer.
//
// This block debounces four active-low keys (up, down, enter, escape). Each
// input word is either a sample tick (s_tuser low) carrying the raw line
// levels in s_tdata, or a read (s_tuser high) that returns the pending event
// on the output stream and clears it. Levels are masked with the enable
// register, high samples are counted per key over a window of WINDOW_LENGTH
// ticks, and at the window's end each key that read high throughout becomes
// released and each key that read low throughout becomes held, giving an
// event code of 1/2 (up pressed/released), 3/4 (down), 5/6 (enter) or
// 7/8 (escape); the highest-priority event of the window, escape first,
// replaces the pending event, or none replaces it. The block takes one word
// per clock cycle when not stalled. A word is taken into an input register
// and handled from there by the debounce core; a read's event appears on the
// output in the cycle after the read leaves the input register. The only
// stall comes from the one-word result register: a read waits in the input
// register while the result register still holds an event the consumer has
// not taken, and any word behind it, sample tick or read, waits with it.
// Write the enable mask only while the block is idle.
module four_key_window_debouncer import fkwd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration: key enable mask, bit0 up, bit1 down, bit2 enter, bit3 escape.
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	// Input word stream.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [3:0] key_levels, [7:4] zero
	input  logic       s_tuser,    // [0] command
	// Event stream.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata     // [3:0] event_code, [7:4] zero
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    out_free;
	result_t result;
	event_t  out_code;

	assign in_item.command = cmd_t'(s_tuser);
	assign in_item.levels  = s_tdata[3:0];

	// A stage word moves on unless it is a read that finds the result
	// register still occupied.
	assign advance = valid_s1 && ((item_s1.command == CMD_SAMPLE) || out_free);

	fkwd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fkwd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (advance),
		.item_s1     (item_s1),
		.result      (result)
	);

	fkwd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (out_code)
	);

	assign m_tdata = {4'b0000, out_code};

`ifndef NO_ASSERTIONS
	// A read's event is never written over an untaken one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> out_free)
		else $error("event produced while the result register is occupied");

	// A read that leaves the stage shows up on the output in the next cycle.
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.command == CMD_READ)) |=> m_tvalid)
		else $error("read left the stage but no event word followed");

	// An empty stage always accepts.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while the stage is empty");
`endif

endmodule

/* src/fkwd_in_reg.sv */
// Input register stage that holds one accepted word until the core takes it.
module fkwd_in_reg import fkwd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* src/fkwd_core.sv */
// Debounce state: window counters, held flags, pending event and enable mask.
module fkwd_core import fkwd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_wr_en,
	input  keys_t   cfg_wr_data,
	input  logic    fire,
	input  item_t   item_s1,
	output result_t result
);

	keys_t  key_enable_q;
	pos_t   window_pos_q;
	pos_t   high_cnt_q [NUM_KEYS];
	keys_t  held_q;
	event_t pending_q;

	keys_t  masked;
	pos_t   pos_next;
	logic   close_window;
	pos_t   cnt_next [NUM_KEYS];
	keys_t  held_next;
	event_t ev_next;

	assign masked       = item_s1.levels & key_enable_q;
	assign pos_next     = window_pos_q + 1'b1;
	assign close_window = (pos_next >= POS_W'(WINDOW_LENGTH));

	always_comb begin
		ev_next   = EV_NONE;
		held_next = held_q;
		for (int k = 0; k < NUM_KEYS; k++) begin
			cnt_next[k] = high_cnt_q[k] + pos_t'(masked[k]);
			if (cnt_next[k] == POS_W'(WINDOW_LENGTH)) begin
				if (held_q[k]) begin
					ev_next = RELEASE_CODE[k];
				end
				held_next[k] = 1'b0;
			end else if (cnt_next[k] == '0) begin
				if (!held_q[k]) begin
					ev_next = PRESS_CODE[k];
				end
				held_next[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_enable_q <= '1;
			window_pos_q <= '0;
			held_q       <= '0;
			pending_q    <= EV_NONE;
			for (int k = 0; k < NUM_KEYS; k++) begin
				high_cnt_q[k] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				key_enable_q <= cfg_wr_data;
			end
			if (fire) begin
				if (item_s1.command == CMD_READ) begin
					pending_q <= EV_NONE;
				end else if (close_window) begin
					window_pos_q <= '0;
					held_q       <= held_next;
					pending_q    <= ev_next;
					for (int k = 0; k < NUM_KEYS; k++) begin
						high_cnt_q[k] <= '0;
					end
				end else begin
					window_pos_q <= pos_next;
					for (int k = 0; k < NUM_KEYS; k++) begin
						high_cnt_q[k] <= cnt_next[k];
					end
				end
			end
		end
	end

	assign result.valid = fire && (item_s1.command == CMD_READ);
	assign result.code  = pending_q;

endmodule

/* src/fkwd_out_reg.sv */
// Result register that holds one event word until the consumer takes it.
module fkwd_out_reg import fkwd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  result_t result,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_ready,
	output event_t  out_code
);

	logic   valid_q;
	event_t code_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_code  = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid && out_free) begin
			code_q <= result.code;
		end
	end

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the four-key window debouncer with a scoreboard class.
module testbench;
	import fkwd_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_WORDS   = 116;
	localparam int NUM_PHASES    = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int IDLE_PERCENT  = 29;
	localparam int READ_PERCENT  = 14;

	// Per-window drive pattern of one key line.
	typedef enum logic [1:0] {
		PAT_HIGH,
		PAT_LOW,
		PAT_GLITCH,
		PAT_BOUNCE
	} line_pattern_t;

	// Tracks the debounced key state and the pending event, and holds the
	// events that reads must return, oldest first.
	class key_event_scoreboard;
		keys_t      enable_mask;
		logic [4:0] window_pos;
		logic [4:0] high_count [NUM_KEYS];
		keys_t      held;
		event_t     pending;
		event_t     expected_events [$];
		int         mismatches;
		int         reads_checked;
		int         key_events;

		function new();
			enable_mask = 4'hF;
			window_pos  = '0;
			held        = '0;
			pending     = EV_NONE;
			mismatches  = 0;
			reads_checked = 0;
			key_events  = 0;
			foreach (high_count[k])
				high_count[k] = '0;
		endfunction

		function void write_enable(keys_t mask);
			enable_mask = mask;
		endfunction

		function void note_word(cmd_t command, keys_t levels);
			keys_t  masked;
			event_t window_event;
			if (command == CMD_READ) begin
				expected_events.push_back(pending);
				pending = EV_NONE;
				return;
			end
			masked = levels & enable_mask;
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (masked[k])
					high_count[k] = high_count[k] + 5'd1;
			end
			window_pos = window_pos + 5'd1;
			if (window_pos >= WINDOW_LENGTH) begin
				// Window closes: later keys in the loop win, so escape has priority.
				window_event = EV_NONE;
				for (int k = 0; k < NUM_KEYS; k++) begin
					if (high_count[k] == WINDOW_LENGTH) begin
						if (held[k])
							window_event = RELEASE_CODE[k];
						held[k] = 1'b0;
					end else if (high_count[k] == 0) begin
						if (!held[k])
							window_event = PRESS_CODE[k];
						held[k] = 1'b1;
					end
					high_count[k] = '0;
				end
				pending    = window_event;
				window_pos = '0;
			end
		endfunction

		function void check_event(logic [7:0] word);
			event_t want;
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event word %h with no read outstanding", word);
				return;
			end
			want = expected_events.pop_front();
			reads_checked++;
			if (want != EV_NONE)
				key_events++;
			if (word[3:0] != want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("event_code mismatch: expected %0d, got %0d", want, word[3:0]);
			end
			if (word[7:4] != 4'd0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("event padding mismatch: expected 0, got %h", word[7:4]);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;

	key_event_scoreboard scoreboard;

	// Stimulus controls shared with the receiver process.
	bit quiet_run;
	bit hold_request;

	// Pattern generator state; gen_pos follows the block's window position.
	int            gen_pos;
	line_pattern_t line_pattern [NUM_KEYS];
	int            glitch_slot  [NUM_KEYS];
	bit            glitch_level [NUM_KEYS];
	bit            noise_window;

	int words_sent;
	int read_words;
	int settings_used;

	four_key_window_debouncer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("four_key_window_debouncer regression: fail");
		$finish;
	end

	// Handshakes are sampled at the falling edge, where the values that the
	// next rising edge will see are already settled.
	always @(negedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			scoreboard.note_word(cmd_t'(s_tuser), keys_t'(s_tdata[3:0]));
		if (arst_n && m_tvalid && m_tready)
			scoreboard.check_event(m_tdata);
	end

	// Event consumer: random stalls, one long hold-off on request, none in quiet runs.
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
				m_tready    <= 1'b0;
			end else if (quiet_run) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Next sample levels. Most windows hold each line steady so that keys
	// really change state; the rest carry one glitch, bounce, or pure noise.
	function automatic keys_t next_levels();
		keys_t levels;
		int    pick;
		if (gen_pos == 0) begin
			noise_window = ($urandom_range(9) == 0);
			for (int k = 0; k < NUM_KEYS; k++) begin
				pick = $urandom_range(9);
				if (pick < 4)
					line_pattern[k] = PAT_HIGH;
				else if (pick < 7)
					line_pattern[k] = PAT_LOW;
				else if (pick < 9)
					line_pattern[k] = PAT_GLITCH;
				else
					line_pattern[k] = PAT_BOUNCE;
				glitch_slot[k]  = $urandom_range(WINDOW_LENGTH - 1);
				glitch_level[k] = 1'($urandom_range(1));
			end
		end
		for (int k = 0; k < NUM_KEYS; k++) begin
			case (line_pattern[k])
				PAT_HIGH:   levels[k] = 1'b1;
				PAT_LOW:    levels[k] = 1'b0;
				PAT_GLITCH: levels[k] = (gen_pos == glitch_slot[k]) ?
					glitch_level[k] : !glitch_level[k];
				default:    levels[k] = 1'($urandom_range(1));
			endcase
		end
		if (noise_window)
			levels = keys_t'($urandom_range(15));
		gen_pos = (gen_pos + 1) % WINDOW_LENGTH;
		return levels;
	endfunction

	// Offers one word and returns just after the edge that accepts it.
	task automatic send_word(cmd_t command, keys_t levels);
		int  idle_cycles;
		bit  taken;
		idle_cycles = 0;
		if (!quiet_run) begin
			while ($urandom_range(99) < IDLE_PERCENT)
				idle_cycles++;
		end
		if (idle_cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle_cycles) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= command;
		s_tdata  <= {4'd0, levels};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		words_sent++;
		if (command == CMD_READ)
			read_words++;
	endtask

	// Stops offering words and waits until every read has been answered and
	// the last sample ticks have passed through the core.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (scoreboard.expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable_mask(keys_t mask);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mask;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		scoreboard.write_enable(mask);
		settings_used++;
	endtask

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < READ_PERCENT)
				send_word(CMD_READ, keys_t'($urandom_range(15)));
			else
				send_word(CMD_SAMPLE, next_levels());
		end
	endtask

	initial begin
		keys_t phase_mask [NUM_PHASES];
		int    failures;

		scoreboard   = new();
		quiet_run    = 1'b0;
		hold_request = 1'b0;
		gen_pos      = 0;
		words_sent   = 0;
		read_words   = 0;
		settings_used = 1;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = 4'd0;
		s_tvalid     = 1'b0;
		s_tuser      = CMD_SAMPLE;
		s_tdata      = 8'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: read at reset, a full window of pressed lines split by a
		// read before the window closes, then a read that clears the event.
		send_word(CMD_READ, 4'hF);
		for (int n = 0; n < 10; n++)
			send_word(CMD_SAMPLE, 4'h0);
		send_word(CMD_READ, 4'h0);
		for (int n = 0; n < 10; n++)
			send_word(CMD_SAMPLE, 4'h0);
		send_word(CMD_READ, 4'h0);
		send_word(CMD_SAMPLE, 4'hF);
		send_word(CMD_READ, 4'hF);
		gen_pos = 1;
		drain();

		// All keys off, all on, alternating halves, single keys and one random mask.
		phase_mask = '{4'h0, 4'hF, 4'h5, 4'hA, 4'h8, 4'h0, 4'h1, 4'hF};
		phase_mask[5] = keys_t'($urandom_range(15));
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_enable_mask(phase_mask[p]);
			quiet_run = (p == 3);
			if (p == 1)
				hold_request = 1'b1;
			random_phase(PHASE_WORDS);
			drain();
		end
		quiet_run = 1'b0;

		failures = scoreboard.mismatches + scoreboard.expected_events.size();
		$display("Sent %0d words, %0d of them reads, under %0d enable mask settings.",
			words_sent, read_words, settings_used);
		$display("Checked %0d event reads, %0d carried a key event; %0d failures.",
			scoreboard.reads_checked, scoreboard.key_events, failures);
		if (failures == 0)
			$display("four_key_window_debouncer regression: pass");
		else
			$display("four_key_window_debouncer regression: fail");
		$finish;
	end

endmodule

/* files.f */
src/fkwd_pkg.sv
src/fkwd_in_reg.sv
src/fkwd_core.sv
src/fkwd_out_reg.sv
src/four_key_window_debouncer.sv
bench/testbench.sv
